// File: sv/lis_patience_binary_search_top_assert.svh
// Assertion macros shared by the checker of the LIS block.
// Each macro expands to one labeled concurrent assertion that is clocked on clk
// and switched off while rst is high.
`ifndef LIS_PATIENCE_BINARY_SEARCH_TOP_ASSERT_SVH
`define LIS_PATIENCE_BINARY_SEARCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LISPBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LISPBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lispbs_pkg.sv
// ----------------------------------------------------------------------------
// lispbs_pkg
// Shared types for the longest increasing subsequence block: the command word
// from the controller to the datapath, the status word that goes back, and
// the fixed width of the run length field.
// ----------------------------------------------------------------------------
package lispbs_pkg;

  // The run length field has a fixed width of 7 bits, which covers 1..64.
  localparam int RUN_LEN_W = 7;

  // These are the commands from the controller. Each one is a strobe that is
  // valid for one cycle.
  typedef struct packed {
    logic take;           // capture the input word
    logic store;          // store the element and start the search
    logic set_ovf;        // drop the element and flag the overflow
    logic srch_rd;        // read tail_value at the search midpoint
    logic srch_upd;       // narrow the search bounds
    logic chk_rd;         // read the tail entry at lo and the position at lo-1
    logic tbl_upd;        // update the tail table and the predecessor link
    logic walk_start;     // read the end of the longest run
    logic cur_from_tp;    // load the walk cursor from tail_position
    logic walk_step;      // record the cursor in the chain and read its link
    logic cur_from_pred;  // load the walk cursor from predecessor
    logic emit_rd_chain;  // read the chain entry k
    logic emit_rd_elem;   // read the stored element for that entry
    logic emit_next;      // advance to the next result
    logic clear;          // end of sequence: clear the count, length and flag
  } cmd_t;

  // This is the status returned by the datapath.
  typedef struct packed {
    logic full;       // the element store is at capacity
    logic final_q;    // the captured word is the final element
    logic lo_lt_hi;   // the binary search is still open
    logic best_zero;  // no run recorded
    logic k_one;      // the walk is at its last step
    logic k_last;     // the current result is the final one
  } sts_t;

endpackage

// File: sv/lispbs_ram.sv
// ----------------------------------------------------------------------------
// lispbs_ram
// A generic single-port-write, single-port-read RAM. The read data is
// registered and holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module lispbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // The write port and the registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lispbs_ctrl.sv
// ----------------------------------------------------------------------------
// lispbs_ctrl
// This is the sequencer of the LIS block. It takes one word at a time and
// steps the datapath through the binary search and the table update. After
// the final element it steps the datapath through the chain walk and the
// emission of the results.
// ----------------------------------------------------------------------------
module lispbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lispbs_pkg::sts_t  sts,
  output lispbs_pkg::cmd_t  cmd
);
  import lispbs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADMIT = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_WALK0 = 4'd5;
  localparam logic [3:0] S_WALK1 = 4'd6;
  localparam logic [3:0] S_WALK2 = 4'd7;
  localparam logic [3:0] S_WALK3 = 4'd8;
  localparam logic [3:0] S_EMIT0 = 4'd9;
  localparam logic [3:0] S_EMIT1 = 4'd10;
  localparam logic [3:0] S_EMIT2 = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  // The state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT2);

  // The next state and the command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_ADMIT;
        end
      end
      S_ADMIT: begin
        if (sts.full) begin
          cmd.set_ovf = 1'b1;
          state_next  = sts.final_q ? S_WALK0 : S_IDLE;
        end else begin
          cmd.store  = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_next  = S_CMP;
        end else begin
          cmd.chk_rd = 1'b1;
          state_next = S_UPD;
        end
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        state_next   = S_SRCH;
      end
      S_UPD: begin
        cmd.tbl_upd = 1'b1;
        state_next  = sts.final_q ? S_WALK0 : S_IDLE;
      end
      S_WALK0: begin
        if (sts.best_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK1;
        end
      end
      S_WALK1: begin
        cmd.cur_from_tp = 1'b1;
        state_next      = S_WALK2;
      end
      S_WALK2: begin
        cmd.walk_step = 1'b1;
        state_next    = sts.k_one ? S_EMIT0 : S_WALK3;
      end
      S_WALK3: begin
        cmd.cur_from_pred = 1'b1;
        state_next        = S_WALK2;
      end
      S_EMIT0: begin
        cmd.emit_rd_chain = 1'b1;
        state_next        = S_EMIT1;
      end
      S_EMIT1: begin
        cmd.emit_rd_elem = 1'b1;
        state_next       = S_EMIT2;
      end
      S_EMIT2: begin
        if (!out_stall) begin
          cmd.emit_next = 1'b1;
          if (sts.k_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lispbs_dp.sv
// ----------------------------------------------------------------------------
// lispbs_dp
// This is the datapath of the LIS block. It holds the element store, the tail
// table, the tail positions, the predecessor links and the chain buffer. It
// also holds the search bounds, the counters and the walk cursor, and it
// performs the compare for each search step.
// ----------------------------------------------------------------------------
module lispbs_dp #(
  parameter int MAX_LEN     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lispbs_pkg::cmd_t                      cmd,
  output lispbs_pkg::sts_t                      sts,
  input  logic signed [VALUE_WIDTH-1:0]         element,
  input  logic                                  final_element,
  output logic signed [VALUE_WIDTH-1:0]         value,
  output logic [lispbs_pkg::RUN_LEN_W-1:0]      run_length,
  output logic                                  is_last,
  output logic                                  overflow
);
  import lispbs_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);

  logic signed [VALUE_WIDTH-1:0] x_q;
  logic                          final_q;
  logic [LEN_W-1:0]              count;
  logic [LEN_W-1:0]              best;
  logic                          ovf;
  logic [LEN_W-1:0]              lo;
  logic [LEN_W-1:0]              hi;
  logic [LEN_W-1:0]              k;
  logic [IDX_W-1:0]              mid;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              cur;

  logic [VALUE_WIDTH-1:0]        es_rdata;
  logic [VALUE_WIDTH-1:0]        tv_rdata;
  logic [IDX_W-1:0]              tp_rdata;
  logic [IDX_W-1:0]              pr_rdata;
  logic [IDX_W-1:0]              ch_rdata;

  logic [LEN_W:0]                mid_sum;
  logic [IDX_W-1:0]              mid_calc;
  logic                          lo_ok;
  logic [LEN_W-1:0]              lo_m1;
  logic [LEN_W-1:0]              best_m1;
  logic [LEN_W-1:0]              k_m1;
  logic [IDX_W-1:0]              lo_addr;
  logic [IDX_W-1:0]              lo_prev_addr;
  logic                          tv_less;
  logic                          tv_eq;
  logic                          tbl_we;
  logic [IDX_W-1:0]              link;
  logic [IDX_W-1:0]              tv_raddr;
  logic [IDX_W-1:0]              tp_raddr;

  // This is the search arithmetic. The midpoint always lies below hi, and
  // therefore below MAX_LEN.
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[IDX_W:1];
  assign lo_ok    = lo < LEN_W'(MAX_LEN);
  assign lo_m1    = lo - 1'b1;
  assign best_m1  = best - 1'b1;
  assign k_m1     = k - 1'b1;

  assign lo_addr      = lo_ok ? lo[IDX_W-1:0] : '0;
  assign lo_prev_addr = (lo == '0) ? '0 : lo_m1[IDX_W-1:0];

  // The tails compare as signed values.
  assign tv_less = $signed(tv_rdata) < x_q;
  assign tv_eq   = (tv_rdata == x_q);

  // An element equal to an existing tail leaves the table unchanged.
  assign tbl_we = cmd.tbl_upd && lo_ok && !((lo < best) && tv_eq);
  assign link   = (lo == '0) ? '0 : tp_rdata;

  assign tv_raddr = cmd.srch_rd ? mid_calc : lo_addr;
  assign tp_raddr = cmd.walk_start ? best_m1[IDX_W-1:0] : lo_prev_addr;

  // These are the counters and the overflow flag. The end of a sequence clears all of them but k.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      best  <= '0;
      ovf   <= 1'b0;
      k     <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        best  <= '0;
        ovf   <= 1'b0;
      end else begin
        if (cmd.store) begin
          count <= count + 1'b1;
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
        if (tbl_we && (lo == best)) begin
          best <= lo + 1'b1;
        end
      end
      if (cmd.walk_start) begin
        k <= best;
      end else if (cmd.walk_step) begin
        k <= k_m1;
      end else if (cmd.emit_next) begin
        k <= k + 1'b1;
      end
    end
  end

  // These are the input capture, the search bounds and the walk cursor.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_q     <= element;
      final_q <= final_element;
    end
    if (cmd.store) begin
      idx <= count[IDX_W-1:0];
      lo  <= '0;
      hi  <= best;
    end
    if (cmd.srch_rd) begin
      mid <= mid_calc;
    end
    if (cmd.srch_upd) begin
      if (tv_less) begin
        lo <= LEN_W'(mid) + 1'b1;
      end else begin
        hi <= LEN_W'(mid);
      end
    end
    if (cmd.cur_from_tp) begin
      cur <= tp_rdata;
    end else if (cmd.cur_from_pred) begin
      cur <= pr_rdata;
    end
  end

  // The element store.
  lispbs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_LEN)) u_elem_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count[IDX_W-1:0]),
    .wdata (x_q),
    .re    (cmd.emit_rd_elem),
    .raddr (ch_rdata),
    .rdata (es_rdata)
  );

  // The smallest tail value for each run length.
  lispbs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_LEN)) u_tail_val_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (lo_addr),
    .wdata (x_q),
    .re    (cmd.srch_rd | cmd.chk_rd),
    .raddr (tv_raddr),
    .rdata (tv_rdata)
  );

  // The index of the element that holds each tail.
  lispbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_tail_pos_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (lo_addr),
    .wdata (idx),
    .re    (cmd.chk_rd | cmd.walk_start),
    .raddr (tp_raddr),
    .rdata (tp_rdata)
  );

  // The predecessor link of each stored element.
  lispbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_pred_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx),
    .wdata (link),
    .re    (cmd.walk_step),
    .raddr (cur),
    .rdata (pr_rdata)
  );

  // The chain buffer. The walk fills it from the back, and the emission reads
  // it from the front.
  lispbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_chain_ram (
    .clk   (clk),
    .we    (cmd.walk_step),
    .waddr (k_m1[IDX_W-1:0]),
    .wdata (cur),
    .re    (cmd.emit_rd_chain),
    .raddr (k[IDX_W-1:0]),
    .rdata (ch_rdata)
  );

  // The status word for the controller.
  assign sts.full      = count >= LEN_W'(MAX_LEN);
  assign sts.final_q   = final_q;
  assign sts.lo_lt_hi  = lo < hi;
  assign sts.best_zero = (best == '0);
  assign sts.k_one     = (k == LEN_W'(1));
  assign sts.k_last    = (k == best_m1);

  // The result fields. They stay stable while the result word waits.
  assign value      = es_rdata;
  assign run_length = RUN_LEN_W'(best);
  assign is_last    = (k == best_m1);
  assign overflow   = ovf;

endmodule

// File: sv/lis_patience_binary_search_top.sv
// ----------------------------------------------------------------------------
// lis_patience_binary_search_top
// Longest strictly increasing subsequence by the patience method with a binary
// search. The block takes a sequence of elements, and after the final element
// it emits the values of the longest run in increasing order.
//
//   channel | handshake          | word fields
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | element, final_element
//   out     | out_valid/out_stall| value, run_length, is_last, overflow
//
// Each element is taken, admitted, searched and written to the tables. The
// search takes at most ceil(log2(run length + 1)) steps. Each step is a read
// of the tail RAM followed by a compare. The run length is at most 63 when an
// element is stored at MAX_LEN = 64. A dropped element skips the search.
// After the final element the walk follows the predecessor links back from the
// end of the longest run, and the emission waits out any output stall.
// One element is processed at a time. in_stall stays high from acceptance
// until the element is done, and during the whole emission.
// Reset is synchronous. It clears the sequencer, the counters and the overflow
// flag. The RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module lis_patience_binary_search_top #(
  parameter int MAX_LEN     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [VALUE_WIDTH-1:0]    element,
  input  logic                             final_element,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [VALUE_WIDTH-1:0]    value,
  output logic [lispbs_pkg::RUN_LEN_W-1:0] run_length,
  output logic                             is_last,
  output logic                             overflow
);
  import lispbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer.
  lispbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The storage and the search datapath.
  lispbs_dp #(.MAX_LEN(MAX_LEN), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .element       (element),
    .final_element (final_element),
    .value         (value),
    .run_length    (run_length),
    .is_last       (is_last),
    .overflow      (overflow)
  );

endmodule

// File: sv/lispbs_checker.sv
// ----------------------------------------------------------------------------
// lispbs_checker
// Port-level checks for the LIS block, bound to the top level. They cover
// input hold under stall, result hold under stall, no input while results are
// pending, the range of the run length, and the gap after the final result.
// ----------------------------------------------------------------------------
`include "lis_patience_binary_search_top_assert.svh"

module lispbs_checker #(
  parameter int MAX_LEN     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic signed [VALUE_WIDTH-1:0]    element,
  input logic                             final_element,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [VALUE_WIDTH-1:0]    value,
  input logic [lispbs_pkg::RUN_LEN_W-1:0] run_length,
  input logic                             is_last,
  input logic                             overflow
);
  import lispbs_pkg::*;

  // A stalled input word holds until it is taken.
  `LISPBS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(element) && $stable(final_element), "input word changed under stall")

  // A stalled result word holds.
  `LISPBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(run_length) && $stable(is_last) && $stable(overflow), "result word changed under stall")

  // No element is taken while a result is pending.
  `LISPBS_ASSERT_NOW(a_no_take_in_emit, out_valid, in_stall, "input open during emission")

  // The run length is within 1..MAX_LEN.
  `LISPBS_ASSERT_NOW(a_len_range, out_valid, (run_length != '0) && (run_length <= RUN_LEN_W'(MAX_LEN)), "run length out of range")

  // The final result ends the emission.
  `LISPBS_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && is_last, !out_valid, "result after final word")

endmodule

bind lis_patience_binary_search_top lispbs_checker #(
  .MAX_LEN     (MAX_LEN),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_lispbs_checker (.*);

// File: bench/lis_patience_binary_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lis_patience_binary_search_top_tb
// Drives sequences of signed words into the longest increasing subsequence
// block and checks every emitted word against a predictor of the patience
// search kept in the bench. Directed sequences cover the value extremes, equal
// values, ordering, a full-length run, capacity overflow and a long output
// hold. Random sequences with bursty input and random output stall follow.
// ----------------------------------------------------------------------------
module lis_patience_binary_search_top_tb;
  import lispbs_pkg::*;

  localparam int MAX_LEN      = 64;
  localparam int VALUE_WIDTH  = 32;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_RISING, STYLE_EXTREME} value_style_t;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RUN_LEN_W-1:0]          run_length;
    logic                          is_last;
    logic                          overflow;
  } run_word_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [VALUE_WIDTH-1:0] element;
  logic                          final_element;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [RUN_LEN_W-1:0]          run_length;
  logic                          is_last;
  logic                          overflow;

  // Expected output words, oldest first.
  run_word_t run_values_q[$];
  int        mismatch_count;
  int        idle_cycles;
  int        burst_left;
  bit        hold_request;

  // Predictor state: the stored sequence and the table of smallest tails.
  logic signed [VALUE_WIDTH-1:0] stored_elem[MAX_LEN];
  logic signed [VALUE_WIDTH-1:0] tail_min[MAX_LEN];
  int                            tail_at[MAX_LEN];
  int                            back_link[MAX_LEN];
  int                            stored_count;
  int                            longest;
  logic                          dropped;

  lis_patience_binary_search_top #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element       (element),
    .final_element (final_element),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .run_length    (run_length),
    .is_last       (is_last),
    .overflow      (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Takes one accepted element into the predicted state. On the final element
  // it walks back from the longest run and queues the run's words in order.
  function automatic void absorb_element(input logic signed [VALUE_WIDTH-1:0] e,
                                         input logic fin);
    int        lo;
    int        hi;
    int        mid;
    int        slot;
    int        len;
    int        cur;
    int        chain[MAX_LEN];
    run_word_t w;
    if (stored_count >= MAX_LEN) begin
      dropped = 1'b1;
    end else begin
      slot = stored_count;
      stored_elem[slot] = e;
      stored_count++;
      // Count the tails that are strictly below the new element.
      lo = 0;
      hi = longest;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tail_min[mid] < e) lo = mid + 1;
        else hi = mid;
      end
      // An element equal to an existing tail leaves the table alone.
      if (lo < MAX_LEN && !(lo < longest && tail_min[lo] == e)) begin
        tail_min[lo]    = e;
        tail_at[lo]     = slot;
        back_link[slot] = (lo == 0) ? 0 : tail_at[lo-1];
        if (lo == longest) longest = lo + 1;
      end
    end
    if (fin) begin
      len = longest;
      if (len > 0) begin
        cur = tail_at[len-1];
        for (int k = len; k > 0; k--) begin
          chain[k-1] = cur;
          cur = back_link[cur];
        end
        for (int k = 0; k < len; k++) begin
          w.value      = stored_elem[chain[k]];
          w.run_length = RUN_LEN_W'(len);
          w.is_last    = (k == len - 1);
          w.overflow   = dropped;
          run_values_q.insert(run_values_q.size(), w);
        end
      end
      stored_count = 0;
      longest      = 0;
      dropped      = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Offers one word on the input channel. The sender works in bursts, and
  // between bursts it drops valid for a random gap.
  task automatic offer_element(input logic signed [VALUE_WIDTH-1:0] e, input logic fin);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(8, 1);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
    end
    in_valid      <= 1'b1;
    element       <= e;
    final_element <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    absorb_element(e, fin);
  endtask

  // One-element sequences at the value extremes.
  task automatic test_single_values();
    offer_element(VAL_MIN, 1'b1);
    offer_element(VAL_MAX, 1'b1);
    offer_element(-1, 1'b1);
    offer_element(0, 1'b1);
  endtask

  // Equal values must not extend a run or replace a tail.
  task automatic test_equal_values();
    offer_element(5, 1'b0);
    offer_element(5, 1'b0);
    offer_element(5, 1'b1);
    offer_element(3, 1'b0);
    offer_element(7, 1'b0);
    offer_element(7, 1'b0);
    offer_element(2, 1'b0);
    offer_element(9, 1'b1);
  endtask

  // Strictly falling, strictly rising, and a run that overtakes via a
  // replaced tail.
  task automatic test_ordering();
    offer_element(VAL_MAX, 1'b0);
    offer_element(100, 1'b0);
    offer_element(0, 1'b0);
    offer_element(VAL_MIN, 1'b1);
    offer_element(VAL_MIN, 1'b0);
    offer_element(-1, 1'b0);
    offer_element(0, 1'b0);
    offer_element(1, 1'b0);
    offer_element(VAL_MAX, 1'b1);
    offer_element(10, 1'b0);
    offer_element(20, 1'b0);
    offer_element(5, 1'b0);
    offer_element(6, 1'b0);
    offer_element(7, 1'b1);
  endtask

  // A rising sequence one longer than the store. The store fills with a run
  // of full length, and the final element itself is dropped.
  task automatic test_capacity_overflow();
    logic signed [VALUE_WIDTH-1:0] v;
    v = VAL_MIN + $urandom_range(1000, 0);
    for (int i = 0; i <= MAX_LEN; i++) begin
      offer_element(v, i == MAX_LEN);
      v = v + $urandom_range(1 << 24, 1);
    end
  endtask

  // The receiver holds off for a long stretch while further elements are
  // offered, so the block backs up into its input.
  task automatic test_output_hold();
    hold_request = 1'b1;
    for (int i = 0; i < 10; i++) offer_element($signed($urandom_range(40, 0)) - 20, i == 9);
    for (int i = 0; i < 6; i++) offer_element($urandom(), i == 5);
  endtask

  // Random sequences, mostly short, with a few long ones.
  task automatic test_random_sequences(input int target);
    int                            sent;
    int                            n;
    value_style_t                  style;
    logic signed [VALUE_WIDTH-1:0] base;
    logic signed [VALUE_WIDTH-1:0] v;
    sent = 0;
    while (sent < target) begin
      n     = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
      style = value_style_t'($urandom_range(3, 0));
      base  = $urandom();
      for (int i = 0; i < n; i++) begin
        case (style)
          STYLE_WIDE: begin
            v = $urandom();
          end
          STYLE_NARROW: begin
            v = $signed($urandom_range(12, 0)) - 6;
          end
          STYLE_RISING: begin
            v = base + i * 4 - $signed($urandom_range(8, 0));
          end
          default: begin
            case ($urandom_range(5, 0))
              0: v = VAL_MIN;
              1: v = VAL_MAX;
              2: v = -1;
              3: v = 0;
              4: v = 1;
              default: v = $urandom();
            endcase
          end
        endcase
        offer_element(v, i == n - 1);
      end
      sent += n;
    end
  endtask

  // Receiver: stall density changes from stretch to stretch, including
  // stretches with no stall at all, and a requested long hold overrides it.
  initial begin : receiver
    int mode_left;
    int stall_pct;
    int hold_left;
    out_stall = 1'b0;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        mode_left = $urandom_range(150, 20);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // Compares each accepted output word with the oldest expected word.
  always @(posedge clk) begin : check_words
    run_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (run_values_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word value=%0d run_length=%0d is_last=%0b overflow=%0b",
                                value, run_length, is_last, overflow));
      end else begin
        w = run_values_q.pop_front();
        if (value !== w.value || run_length !== w.run_length ||
            is_last !== w.is_last || overflow !== w.overflow) begin
          note_mismatch($sformatf(
            "expected value=%0d run_length=%0d is_last=%0b overflow=%0b, got %0d %0d %0b %0b",
            w.value, w.run_length, w.is_last, w.overflow,
            value, run_length, is_last, overflow));
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    element        = '0;
    final_element  = 1'b0;
    hold_request   = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    stored_count   = 0;
    longest        = 0;
    dropped        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_values();
    test_equal_values();
    test_ordering();
    test_capacity_overflow();
    test_output_hold();
    test_random_sequences(12);

    @(negedge clk);
    in_valid <= 1'b0;
    while (run_values_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lispbs_pkg.sv
sv/lispbs_ram.sv
sv/lispbs_ctrl.sv
sv/lispbs_dp.sv
sv/lis_patience_binary_search_top.sv
sv/lispbs_checker.sv
bench/lis_patience_binary_search_top_tb.sv
